[design/truncated_breit_wigner_sampler_core_defines.svh]
// Assertion macros for the truncated Breit-Wigner sampler checker.
// Depends on nothing; included by the checker file only.
`ifndef TRUNCATED_BREIT_WIGNER_SAMPLER_CORE_DEFINES_SVH
`define TRUNCATED_BREIT_WIGNER_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define TBWS_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tbws: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define TBWS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tbws: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define TBWS_ASSERT_ALWAYS_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("tbws: reset check failed");

`endif

[design/tbws_pkg.sv]
// Shared types, widths, constants and the arctangent table of the sampler.
// No dependencies; every other design file but tbws_queue and the macro header imports it.
`timescale 1ns / 1ps
`default_nettype none

package tbws_pkg;

   localparam int CODE_W  = 24;
   localparam int MASS_W  = 22;
   localparam int FRAC_W  = 16;
   localparam int STAT_W  = 2;
   localparam int CUT_W   = 18;

   localparam int CORDIC_STEPS_DEF = 20;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // Datapath widths.
   localparam int XY_W   = 36;
   localparam int ANG_W  = 34;
   localparam int NUM_W  = 55;
   localparam int DEN_W  = 33;
   localparam int QUOT_W = 23;

   localparam logic [MASS_W-1:0] MASS_MAX = '1;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_WIDTH = 2'd1,
      STATUS_BAD_CODE  = 2'd2
   } status_type;

   // Resonance codes (absolute values) and their lower mass cuts in 1/256 MeV.
   localparam logic [CODE_W-1:0] CODE_OMEGA  = 24'd223;
   localparam logic [CODE_W-1:0] CODE_RHO0   = 24'd113;
   localparam logic [CODE_W-1:0] CODE_PHI    = 24'd333;
   localparam logic [CODE_W-1:0] CODE_RHOP   = 24'd213;
   localparam logic [CODE_W-1:0] CODE_KSTAR0 = 24'd313;
   localparam logic [CODE_W-1:0] CODE_KSTARP = 24'd323;

   localparam logic [CUT_W-1:0] CUT_OMEGA  = 18'd34560;
   localparam logic [CUT_W-1:0] CUT_RHO0   = 18'd71455;
   localparam logic [CUT_W-1:0] CUT_PHI    = 18'd106015;
   localparam logic [CUT_W-1:0] CUT_RHOP   = 18'd70285;
   localparam logic [CUT_W-1:0] CUT_KSTAR0 = 18'd161961;
   localparam logic [CUT_W-1:0] CUT_KSTARP = 18'd160937;

   // atan(2^-i) with a full turn equal to 2^32.
   localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81,
      34'sd41,        34'sd20,        34'sd10,        34'sd5,
      34'sd3,         34'sd1,         34'sd1,         34'sd0
   };

   typedef struct packed {
      logic             known;
      logic [CUT_W-1:0] cut;
   } cut_type;

   // One classified item, as it travels from the front end to the back end.
   typedef struct packed {
      status_type        status;
      logic [CUT_W-1:0]  lo;
      logic [MASS_W-1:0] mean;
      logic [MASS_W-1:0] fw;
      logic [MASS_W-1:0] hi;
      logic [FRAC_W-1:0] u;
   } item_type;

   function automatic cut_type lower_cut(input logic [CODE_W-1:0] mag);
      cut_type r;
      r.known = 1'b1;
      case (mag)
         CODE_OMEGA:  r.cut = CUT_OMEGA;
         CODE_RHO0:   r.cut = CUT_RHO0;
         CODE_PHI:    r.cut = CUT_PHI;
         CODE_RHOP:   r.cut = CUT_RHOP;
         CODE_KSTAR0: r.cut = CUT_KSTAR0;
         CODE_KSTARP: r.cut = CUT_KSTARP;
         default: begin
            r.known = 1'b0;
            r.cut   = '0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[design/tbws_if.sv]
// Valid/ready channel interfaces for the sampler's request and response beats.
// Depends on tbws_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tbws_req_if import tbws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CODE_W-1:0] particle_code;
   logic [MASS_W-1:0]        mean_mass;
   logic [MASS_W-1:0]        full_width;
   logic [MASS_W-1:0]        upper_cut;
   logic [FRAC_W-1:0]        uniform_fraction;

   modport source (output valid, particle_code, mean_mass, full_width, upper_cut,
                   uniform_fraction, input ready);
   modport sink   (input valid, particle_code, mean_mass, full_width, upper_cut,
                   uniform_fraction, output ready);
endinterface

interface tbws_rsp_if import tbws_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASS_W-1:0] sampled_mass;
   logic [STAT_W-1:0] status;

   modport source (output valid, sampled_mass, status, input ready);
   modport sink   (input valid, sampled_mass, status, output ready);
endinterface

`default_nettype wire

[design/tbws_front.sv]
// Front end: takes request beats, checks width and code, looks up the lower cut.
// Depends on tbws_pkg and tbws_req_if.
`timescale 1ns / 1ps
`default_nettype none

module tbws_front import tbws_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tbws_req_if.sink  req_if,
   output item_type  item,
   output logic      item_valid,
   input  logic      item_ready
);

   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;
   logic              take;
   logic [CODE_W-1:0] raw;
   logic [CODE_W-1:0] mag;
   cut_type           cut;

   assign take          = !valid_ff || item_ready;
   assign req_if.ready  = take;
   assign raw           = req_if.particle_code;
   assign mag           = raw[CODE_W-1] ? (~raw + 1'b1) : raw;
   assign cut           = lower_cut(mag);

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (take) begin
         valid_in     = req_if.valid;
         item_in.lo   = cut.cut;
         item_in.mean = req_if.mean_mass;
         item_in.fw   = req_if.full_width;
         item_in.hi   = req_if.upper_cut;
         item_in.u    = req_if.uniform_fraction;
         // A zero width wins over an unknown code.
         if (req_if.full_width == '0) begin
            item_in.status = STATUS_BAD_WIDTH;
         end else if (!cut.known) begin
            item_in.status = STATUS_BAD_CODE;
         end else begin
            item_in.status = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

[design/tbws_queue.sv]
// Small register queue that decouples the front end from the back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module tbws_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/tbws_cordic.sv]
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// Depends on tbws_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module tbws_cordic import tbws_pkg::*; #(
   parameter int STEPS  = CORDIC_STEPS_DEF,
   parameter bit VECTOR = 1'b1,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [XY_W-1:0]  in_x,
   input  logic signed [XY_W-1:0]  in_y,
   input  logic signed [ANG_W-1:0] in_z,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [XY_W-1:0]  out_x,
   output logic signed [XY_W-1:0]  out_y,
   output logic signed [ANG_W-1:0] out_z,
   output logic [SIDE_W-1:0]       out_side
);

   logic                    v_ff [STEPS];
   logic signed [XY_W-1:0]  x_ff [STEPS];
   logic signed [XY_W-1:0]  y_ff [STEPS];
   logic signed [ANG_W-1:0] z_ff [STEPS];
   logic [SIDE_W-1:0]       s_ff [STEPS];
   logic                    v_in [STEPS];
   logic signed [XY_W-1:0]  x_in [STEPS];
   logic signed [XY_W-1:0]  y_in [STEPS];
   logic signed [ANG_W-1:0] z_in [STEPS];
   logic [SIDE_W-1:0]       s_in [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      localparam int SH = i % 32;
      logic                    vp;
      logic signed [XY_W-1:0]  xp, yp, xs, ys;
      logic signed [ANG_W-1:0] zp;
      logic [SIDE_W-1:0]       sp;
      logic                    plus;

      if (i == 0) begin : g_head
         assign vp = in_valid;
         assign xp = in_x;
         assign yp = in_y;
         assign zp = in_z;
         assign sp = in_side;
      end else begin : g_link
         assign vp = v_ff[i-1];
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign sp = s_ff[i-1];
      end

      assign xs   = xp >>> SH;
      assign ys   = yp >>> SH;
      // Vectoring drives y toward zero, rotation drives z toward zero.
      assign plus = VECTOR ? yp[XY_W-1] : !zp[ANG_W-1];

      assign v_in[i] = vp;
      assign s_in[i] = sp;
      assign x_in[i] = plus ? (xp - ys) : (xp + ys);
      assign y_in[i] = plus ? (yp + xs) : (yp - xs);
      assign z_in[i] = plus ? (zp - ATAN_TAB[SH]) : (zp + ATAN_TAB[SH]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_in[i];
         end
         if (en) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            s_ff[i] <= s_in[i];
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_x     = x_ff[STEPS-1];
   assign out_y     = y_ff[STEPS-1];
   assign out_z     = z_ff[STEPS-1];
   assign out_side  = s_ff[STEPS-1];

endmodule

`default_nettype wire

[design/tbws_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side band.
// Depends on tbws_pkg for its default widths.
`timescale 1ns / 1ps
`default_nettype none

module tbws_div import tbws_pkg::*; #(
   parameter int N_W    = NUM_W,
   parameter int D_W    = DEN_W,
   parameter int Q_W    = QUOT_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [N_W-1:0]    in_num,
   input  logic [D_W-1:0]    in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = D_W + Q_W;

   logic              v_ff [Q_W];
   logic [N_W-1:0]    r_ff [Q_W];
   logic [D_W-1:0]    d_ff [Q_W];
   logic [Q_W-1:0]    q_ff [Q_W];
   logic [SIDE_W-1:0] s_ff [Q_W];
   logic              v_in [Q_W];
   logic [N_W-1:0]    r_in [Q_W];
   logic [D_W-1:0]    d_in [Q_W];
   logic [Q_W-1:0]    q_in [Q_W];
   logic [SIDE_W-1:0] s_in [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      localparam int B = Q_W - 1 - i;
      logic              vp;
      logic [N_W-1:0]    rp;
      logic [D_W-1:0]    dp;
      logic [Q_W-1:0]    qp;
      logic [SIDE_W-1:0] sp;
      logic [CMP_W-1:0]  rem_w, sub_w;
      logic              ge;

      if (i == 0) begin : g_head
         assign vp = in_valid;
         assign rp = in_num;
         assign dp = in_den;
         assign qp = '0;
         assign sp = in_side;
      end else begin : g_link
         assign vp = v_ff[i-1];
         assign rp = r_ff[i-1];
         assign dp = d_ff[i-1];
         assign qp = q_ff[i-1];
         assign sp = s_ff[i-1];
      end

      assign rem_w   = CMP_W'(rp);
      assign sub_w   = CMP_W'(dp) << B;
      assign ge      = rem_w >= sub_w;
      assign v_in[i] = vp;
      assign d_in[i] = dp;
      assign s_in[i] = sp;
      assign r_in[i] = ge ? N_W'(rem_w - sub_w) : rp;
      assign q_in[i] = qp | (Q_W'(ge) << B);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_W; i++) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_in[i];
         end
         if (en) begin
            r_ff[i] <= r_in[i];
            d_ff[i] <= d_in[i];
            q_ff[i] <= q_in[i];
            s_ff[i] <= s_in[i];
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_quot  = q_ff[Q_W-1];
   assign out_side  = s_ff[Q_W-1];

endmodule

`default_nettype wire

[design/tbws_back.sv]
// Back end: two arctangents, interpolation, tangent, divide, clamp, response register.
// Depends on tbws_pkg, tbws_cordic, tbws_div and tbws_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module tbws_back import tbws_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       item_valid,
   output logic       item_ready,
   tbws_rsp_if.source rsp_if
);

   typedef struct packed {
      status_type        status;
      logic [MASS_W-1:0] mean;
      logic [MASS_W-1:0] fw;
   } meta_type;

   typedef struct packed {
      status_type        status;
      logic [MASS_W-1:0] mean;
      logic              xneg;
      logic              ypos;
      logic              neg;
      logic              ovf;
   } tail_type;

   localparam int META_W = $bits(meta_type);
   localparam int TAIL_W = $bits(tail_type);
   localparam int PROD_W = ANG_W + 1 + FRAC_W + 1;
   localparam int MUL_W  = NUM_W + 1;
   localparam logic signed [XY_W-1:0] ROT_X0 = XY_W'(64'd1 << 30);

   logic adv;

   // Entry stage.
   logic                   e_valid_ff;
   logic signed [XY_W-1:0] e_x_ff, e_y1_ff, e_y2_ff;
   meta_type               e_meta_ff, e_meta_in;
   logic [FRAC_W-1:0]      e_u_ff;
   logic signed [23:0]     d1, d2;

   // Arctangent outputs.
   logic                    va, vb;
   logic signed [XY_W-1:0]  va_x, va_y, vb_x, vb_y;
   logic signed [ANG_W-1:0] a1, a2;
   logic [META_W-1:0]       va_side;
   logic [FRAC_W-1:0]       vb_side;

   // Interpolation.
   logic                     i1_valid_ff;
   logic signed [PROD_W-1:0] i1_prod_ff, i1_prod_in;
   logic signed [ANG_W-1:0]  i1_a1_ff;
   logic [META_W-1:0]        i1_meta_ff;
   logic signed [ANG_W:0]    span;
   logic                     i2_valid_ff;
   logic signed [ANG_W-1:0]  i2_a_ff, i2_a_in;
   logic [META_W-1:0]        i2_meta_ff;

   // Tangent outputs.
   logic                    rv;
   logic signed [XY_W-1:0]  rx, ry;
   logic signed [ANG_W-1:0] rz;
   logic [META_W-1:0]       r_side;
   meta_type                r_meta;

   // Product, magnitude and overflow stages.
   logic                    m_valid_ff;
   logic signed [MUL_W-1:0] m_num_ff, m_num_in;
   logic [31:0]             m_xr_ff;
   logic                    m_xneg_ff, m_ypos_ff;
   meta_type                m_meta_ff;
   logic                    a_valid_ff;
   logic [NUM_W-1:0]        a_n_ff, a_n_in;
   logic [DEN_W-1:0]        a_d_ff;
   logic                    a_neg_ff, a_xneg_ff, a_ypos_ff;
   meta_type                a_meta_ff;
   logic                    o_valid_ff;
   logic [NUM_W-1:0]        o_n_ff;
   logic [DEN_W-1:0]        o_d_ff;
   tail_type                o_tail_ff, o_tail_in;

   // Divider outputs and final stage.
   logic                      dv;
   logic [QUOT_W-1:0]         dq;
   logic [TAIL_W-1:0]         d_side;
   tail_type                  d_tail;
   logic signed [MASS_W+2:0]  sum;
   logic [MASS_W-1:0]         mass_in;
   logic                      rsp_valid_ff;
   logic [MASS_W-1:0]         rsp_mass_ff;
   status_type                rsp_status_ff;

   // The whole pipeline moves when the response register is free.
   assign adv        = !rsp_valid_ff || rsp_if.ready;
   assign item_ready = adv;

   assign d1 = $signed({6'b0, item.lo}) - $signed({2'b0, item.mean});
   assign d2 = $signed({2'b0, item.hi}) - $signed({2'b0, item.mean});

   always_comb begin
      e_meta_in.status = item.status;
      e_meta_in.mean   = item.mean;
      e_meta_in.fw     = item.fw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= item_valid;
      end
      if (adv) begin
         e_x_ff    <= XY_W'({item.fw, 8'h00});
         e_y1_ff   <= {{(XY_W-33){d1[23]}}, d1, 9'h000};
         e_y2_ff   <= {{(XY_W-33){d2[23]}}, d2, 9'h000};
         e_meta_ff <= e_meta_in;
         e_u_ff    <= item.u;
      end
   end

   tbws_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .SIDE_W(META_W)) u_atan_lo (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (e_valid_ff),
      .in_x     (e_x_ff),
      .in_y     (e_y1_ff),
      .in_z     ('0),
      .in_side  (e_meta_ff),
      .out_valid(va),
      .out_x    (va_x),
      .out_y    (va_y),
      .out_z    (a1),
      .out_side (va_side)
   );

   tbws_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .SIDE_W(FRAC_W)) u_atan_hi (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (e_valid_ff),
      .in_x     (e_x_ff),
      .in_y     (e_y2_ff),
      .in_z     ('0),
      .in_side  (e_u_ff),
      .out_valid(vb),
      .out_x    (vb_x),
      .out_y    (vb_y),
      .out_z    (a2),
      .out_side (vb_side)
   );

   assign span       = {a2[ANG_W-1], a2} - {a1[ANG_W-1], a1};
   assign i1_prod_in = span * $signed({1'b0, vb_side});
   assign i2_a_in    = i1_a1_ff + ANG_W'(i1_prod_ff >>> FRAC_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_valid_ff <= 1'b0;
         i2_valid_ff <= 1'b0;
      end else if (adv) begin
         i1_valid_ff <= va && vb;
         i2_valid_ff <= i1_valid_ff;
      end
      if (adv) begin
         i1_prod_ff <= i1_prod_in;
         i1_a1_ff   <= a1;
         i1_meta_ff <= va_side;
         i2_a_ff    <= i2_a_in;
         i2_meta_ff <= i1_meta_ff;
      end
   end

   tbws_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .SIDE_W(META_W)) u_tan (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (i2_valid_ff),
      .in_x     (ROT_X0),
      .in_y     ('0),
      .in_z     (i2_a_ff),
      .in_side  (i2_meta_ff),
      .out_valid(rv),
      .out_x    (rx),
      .out_y    (ry),
      .out_z    (rz),
      .out_side (r_side)
   );

   assign r_meta   = meta_type'(r_side);
   assign m_num_in = $signed({1'b0, r_meta.fw}) * $signed(ry[32:0]);
   assign a_n_in   = NUM_W'(m_num_ff[MUL_W-1] ? -m_num_ff : m_num_ff);

   always_comb begin
      o_tail_in.status = a_meta_ff.status;
      o_tail_in.mean   = a_meta_ff.mean;
      o_tail_in.xneg   = a_xneg_ff;
      o_tail_in.ypos   = a_ypos_ff;
      o_tail_in.neg    = a_neg_ff;
      // A quotient of 2^23 or more saturates the mass whatever the mean.
      o_tail_in.ovf    = {1'b0, a_n_ff} >= {a_d_ff, QUOT_W'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= rv;
         a_valid_ff <= m_valid_ff;
         o_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         m_num_ff  <= m_num_in;
         m_xr_ff   <= rx[31:0];
         m_xneg_ff <= rx[XY_W-1] || (rx == '0) || (rz == '0 && 1'b0);
         m_ypos_ff <= !ry[XY_W-1];
         m_meta_ff <= r_meta;
         a_n_ff    <= a_n_in;
         a_d_ff    <= {m_xr_ff, 1'b0};
         a_neg_ff  <= m_num_ff[MUL_W-1];
         a_xneg_ff <= m_xneg_ff;
         a_ypos_ff <= m_ypos_ff;
         a_meta_ff <= m_meta_ff;
         o_n_ff    <= a_n_ff;
         o_d_ff    <= a_d_ff;
         o_tail_ff <= o_tail_in;
      end
   end

   tbws_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QUOT_W), .SIDE_W(TAIL_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (o_valid_ff),
      .in_num   (o_n_ff),
      .in_den   (o_d_ff),
      .in_side  (o_tail_ff),
      .out_valid(dv),
      .out_quot (dq),
      .out_side (d_side)
   );

   assign d_tail = tail_type'(d_side);
   assign sum    = d_tail.neg ? ($signed({3'b0, d_tail.mean}) - $signed({2'b0, dq}))
                              : ($signed({3'b0, d_tail.mean}) + $signed({2'b0, dq}));

   always_comb begin
      if (d_tail.status != STATUS_OK) begin
         mass_in = '0;
      end else if (d_tail.xneg) begin
         mass_in = d_tail.ypos ? MASS_MAX : '0;
      end else if (d_tail.ovf) begin
         mass_in = d_tail.neg ? '0 : MASS_MAX;
      end else if (sum[MASS_W+2]) begin
         mass_in = '0;
      end else if (sum > $signed({3'b0, MASS_MAX})) begin
         mass_in = MASS_MAX;
      end else begin
         mass_in = sum[MASS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv;
      end
      if (adv) begin
         rsp_mass_ff   <= mass_in;
         rsp_status_ff <= d_tail.status;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sampled_mass = rsp_mass_ff;
   assign rsp_if.status       = rsp_status_ff;

   // The x and y residues of the vectoring units carry no information here;
   // they are folded into nothing and left to synthesis to trim.
   logic unused_residue;
   assign unused_residue = ^{va_x, va_y, vb_x, vb_y};

endmodule

`default_nettype wire

[design/truncated_breit_wigner_sampler_core.sv]
// Truncated Breit-Wigner mass sampler, top level. Depends on tbws_pkg, tbws_if,
// tbws_front, tbws_queue and tbws_back.
// Throughput: one beat per cycle while the response is taken, set by the fully pipelined CORDIC and divider stages.
// Reset: synchronous, active high; clears every valid bit and the queue, no other state.
`timescale 1ns / 1ps
`default_nettype none

module truncated_breit_wigner_sampler_core import tbws_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tbws_req_if.sink   req_if,
   tbws_rsp_if.source rsp_if
);

   // The front end classifies each request beat: a zero width gives the
   // width status, an unknown |code| gives the code status, and otherwise
   // the code selects the lower mass cut.
   item_type f_item;
   logic     f_valid, f_ready;
   item_type q_item;
   logic     q_valid, q_ready;

   tbws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .item      (f_item),
      .item_valid(f_valid),
      .item_ready(f_ready)
   );

   // The queue lets the front end keep taking beats until it fills while
   // the back end is held by a stalled response.
   tbws_queue #(.WIDTH($bits(item_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_data (f_item),
      .push_ready(f_ready),
      .pop_valid (q_valid),
      .pop_data  (q_item),
      .pop_ready (q_ready)
   );

   // The back end computes the two cut angles by vectoring CORDIC, picks an
   // angle between them by the uniform fraction, rotates a unit vector by it
   // and divides sine by cosine scaled by the width, then clamps the mass.
   tbws_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .item      (q_item),
      .item_valid(q_valid),
      .item_ready(q_ready),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

[design/tbws_checker.sv]
// Port-level checker for the sampler, bound to the top level.
// Depends on tbws_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "truncated_breit_wigner_sampler_core_defines.svh"

module tbws_checker import tbws_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MASS_W-1:0] rsp_sampled_mass,
   input logic [STAT_W-1:0] rsp_status
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // A held response keeps its payload.
   `TBWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sampled_mass) && $stable(rsp_status))
   // An error beat always carries a zero mass.
   `TBWS_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_sampled_mass == '0)
   // Only the three defined status codes appear.
   `TBWS_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_BAD_WIDTH || rsp_status == STATUS_BAD_CODE)
   // Nothing is presented right after reset.
   `TBWS_ASSERT_ALWAYS_NEXT(a_reset_quiet, clock, reset || req_beat, !rsp_valid || !$past(reset))

endmodule

bind truncated_breit_wigner_sampler_core tbws_checker u_tbws_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_sampled_mass(rsp_if.sampled_mass),
   .rsp_status      (rsp_if.status)
);

`default_nettype wire
